@@ hw/rtl/sine_phase_accumulator_oscillator_macros.svh @@
// Assertion helpers for the oscillator checker
`ifndef SINE_PHASE_ACCUMULATOR_OSCILLATOR_MACROS_SVH
`define SINE_PHASE_ACCUMULATOR_OSCILLATOR_MACROS_SVH

// same-cycle implication
`define SPAO_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPAO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that stays live through reset
`define SPAO_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/spao_pkg.sv @@
package spao_pkg;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] HALF_Q30    = 64'd1 << 29;

   localparam int PHASE_BITS  = 32;
   localparam int SAMPLE_FIELD = 16;

   // Quarter-wave sine entry k, evaluated at elaboration only
   function automatic logic [63:0] rom_entry(input logic [63:0] k, input int addr_bits,
                                             input int sample_bits);
      logic [63:0]        t;
      logic [63:0]        t2;
      logic [63:0]        mag;
      logic [63:0]        s;
      logic [63:0]        amp;
      logic [63:0]        v;
      logic signed [63:0] sum;
      t   = (k * HALF_PI_Q30) >> addr_bits;
      t2  = (t * t) >> 30;
      mag = t;
      sum = signed'(t);
      mag = ((mag * t2) >> 30) / 64'd6;
      sum = sum - signed'(mag);
      mag = ((mag * t2) >> 30) / 64'd20;
      sum = sum + signed'(mag);
      mag = ((mag * t2) >> 30) / 64'd42;
      sum = sum - signed'(mag);
      mag = ((mag * t2) >> 30) / 64'd72;
      sum = sum + signed'(mag);
      mag = ((mag * t2) >> 30) / 64'd110;
      sum = sum - signed'(mag);
      mag = ((mag * t2) >> 30) / 64'd156;
      sum = sum + signed'(mag);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > signed'(ONE_Q30)) begin
         sum = signed'(ONE_Q30);
      end
      s   = unsigned'(sum);
      amp = (64'd1 << (sample_bits - 1)) - 64'd1;
      v   = (s * amp + HALF_Q30) >> 30;
      if (v > amp) begin
         v = amp;
      end
      return v;
   endfunction

endpackage

@@ hw/rtl/spao_sine_rom.sv @@
module spao_sine_rom #(
   parameter int ADDR_BITS   = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [ADDR_BITS:0]     rd_addr,
   output logic [SAMPLE_BITS-2:0] rd_data
);

   localparam int DEPTH = (1 << ADDR_BITS) + 1;

   typedef logic [SAMPLE_BITS-2:0] word_type;
   typedef word_type rom_array_type [DEPTH];

   function automatic rom_array_type build_rom();
      rom_array_type r;
      for (int k = 0; k < DEPTH; k++) begin
         r[k] = word_type'(spao_pkg::rom_entry(64'(k), ADDR_BITS, SAMPLE_BITS));
      end
      return r;
   endfunction

   localparam rom_array_type ROM_TABLE = build_rom();

   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ROM_TABLE[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sine_phase_accumulator_oscillator.sv @@
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata[31:0] phase_step, tlast last_of_block
// rsp      out  rsp_tvalid/rsp_tready  tdata[15:0] sample
// csr      in   csr_wr_en              csr_wr_data[31:0] start_phase
//
// One item per cycle while rsp is not stalled. Each taken item goes through phase add and
// ROM address, then registered ROM read, then sign and output register, to its result.
// Reset (synchronous) clears start phase, pipeline valids and restarts a block.
// A stalled result holds the output stage, and the ROM stage when it is full; req_tready drops only when both are full.
module sine_phase_accumulator_oscillator #(
   parameter int TABLE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] phase_step
   input  logic        req_tlast,   // last_of_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int PB   = spao_pkg::PHASE_BITS;
   localparam int SF   = spao_pkg::SAMPLE_FIELD;
   localparam int WIDE = (SAMPLE_BITS > SF) ? SAMPLE_BITS : SF;
   localparam logic [TABLE_ADDR_BITS:0] QUARTER = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

   logic [PB-1:0] start_phase_ff;
   logic [PB-1:0] phase_acc_ff, phase_acc_in;
   logic [PB-1:0] held_step_ff, held_step_in;
   logic          phase_loaded_ff, phase_loaded_in;
   logic          block_start_ff, block_start_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_neg_ff;
   logic          s2_valid_ff, s2_valid_in;
   logic [SF-1:0] sample_ff, sample_in;

   logic                       en1, en2, accept;
   logic [PB-1:0]              phase_cur, step_cur;
   logic [TABLE_ADDR_BITS-1:0] idx;
   logic [TABLE_ADDR_BITS:0]   rom_addr;
   logic [SAMPLE_BITS-2:0]     rom_data;
   logic [WIDE-1:0]            mag_wide, val_wide;

   assign en2        = !s2_valid_ff || rsp_tready;
   assign en1        = en2 || !s1_valid_ff;
   assign req_tready = en1;
   assign accept     = req_tvalid && en1;

   assign phase_cur = phase_loaded_ff ? phase_acc_ff : start_phase_ff;
   assign step_cur  = block_start_ff ? req_tdata : held_step_ff;
   assign idx       = phase_cur[PB-3 -: TABLE_ADDR_BITS];
   assign rom_addr  = phase_cur[PB-2] ? (QUARTER - {1'b0, idx}) : {1'b0, idx};

   always_comb begin
      phase_acc_in    = phase_acc_ff;
      held_step_in    = held_step_ff;
      phase_loaded_in = phase_loaded_ff;
      block_start_in  = block_start_ff;
      if (accept) begin
         phase_acc_in    = phase_cur + step_cur;
         held_step_in    = step_cur;
         phase_loaded_in = 1'b1;
         block_start_in  = req_tlast;
      end
   end

   assign s1_valid_in = en1 ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;

   spao_sine_rom #(
      .ADDR_BITS   (TABLE_ADDR_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (en1),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   assign mag_wide  = {{(WIDE - SAMPLE_BITS + 1){1'b0}}, rom_data};
   assign val_wide  = s1_neg_ff ? (~mag_wide + 1'b1) : mag_wide;
   assign sample_in = val_wide[SF-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_phase_ff   <= '0;
         phase_acc_ff     <= '0;
         held_step_ff     <= '0;
         phase_loaded_ff  <= 1'b0;
         block_start_ff   <= 1'b1;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            start_phase_ff <= csr_wr_data;
         end
         phase_acc_ff    <= phase_acc_in;
         held_step_ff    <= held_step_in;
         phase_loaded_ff <= phase_loaded_in;
         block_start_ff  <= block_start_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_neg_ff <= phase_cur[PB-1];
      end
      if (en2) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = sample_ff;

endmodule

@@ hw/rtl/spao_checker.sv @@
`include "sine_phase_accumulator_oscillator_macros.svh"

module spao_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   `SPAO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled rsp item changed")
   `SPAO_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "rsp valid straight after reset")
   `SPAO_ASSERT_IMPL(a_latency, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "rsp item without req item two cycles before")
   `SPAO_ASSERT_IMPL(a_ready_full, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "req stalled while output not blocked")

endmodule

bind sine_phase_accumulator_oscillator spao_checker u_spao_checker (.*);
